// ----- rtl/adcbcd_pkg.sv -----
// Package for the averaging voltmeter display block: widths, codes, FSM type,
// divider request/response structs and the digit conversion functions.
// Depends on nothing; every other file of the block imports it.
package adcbcd_pkg;

	localparam int unsigned MAX_SAMPLES_DEF = 16;

	localparam int CFG_W    = 5;
	localparam int SAMPLE_W = 10;
	localparam int SUM_W    = 14;
	localparam int SHOWN_W  = 7;
	localparam int SEG_W    = 7;
	localparam int DEN_W    = 2;
	localparam int DIV_W    = 16;
	localparam int DVS_W    = 10;
	localparam int PADDR_W  = 3;

	localparam logic [CFG_W-1:0]   SPA_RESET = 5'd2;
	localparam logic [SAMPLE_W-1:0] AVG_MAX  = 10'd1023;
	localparam logic [DIV_W-1:0]   SCALE_MUL = 16'd45;
	localparam logic [DIV_W-1:0]   SCALE_RND = 16'd511;
	localparam logic [DVS_W-1:0]   SCALE_DIV = 10'd1023;
	localparam logic [SHOWN_W-1:0] SCALE_OFS = 7'd20;

	// The scale divisor is one less than 2**SCALE_SHIFT.
	localparam int SCALE_SHIFT = 10;

	localparam logic [DEN_W-1:0] DEN_LOW  = 2'd1;
	localparam logic [DEN_W-1:0] DEN_HIGH = 2'd2;

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_TICK   = 1'b1
	} cmd_t;

	typedef enum logic {
		REG_SPA = 1'b0
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV1,
		ST_SCALE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic [3:0] tens;
		logic [3:0] units;
	} bcd_t;

	// Two BCD digits of a 7-bit value; the tens digit wraps as in a modulo-100 split.
	function automatic bcd_t to_bcd(input logic [SHOWN_W-1:0] v);
		logic [14:0] prod;
		logic [3:0]  t;
		logic [6:0]  tx10;
		bcd_t        r;
		prod   = 15'(v) * 15'd205;
		t      = prod[14:11];
		tx10   = 7'(t) * 7'd10;
		r.units = 4'(v - tx10);
		r.tens  = (t >= 4'd10) ? 4'(t - 4'd10) : t;
		return r;
	endfunction

	// Seven-segment code, bit 0 is segment a.
	function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0:    s = 7'h3F;
			4'd1:    s = 7'h06;
			4'd2:    s = 7'h5B;
			4'd3:    s = 7'h4F;
			4'd4:    s = 7'h66;
			4'd5:    s = 7'h6D;
			4'd6:    s = 7'h7D;
			4'd7:    s = 7'h07;
			4'd8:    s = 7'h7F;
			4'd9:    s = 7'h6F;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

// ----- rtl/adcbcd_if.sv -----
// Valid/ready channel interfaces for the request input and the display output.
// Depends on adcbcd_pkg for field widths.
interface adcbcd_in_if import adcbcd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                cmd;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, cmd, sample, input ready);
	modport sink   (input valid, cmd, sample, output ready);
endinterface

interface adcbcd_out_if import adcbcd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [DEN_W-1:0] digit_enable;
	logic [SEG_W-1:0] segments;

	modport source (output valid, digit_enable, segments, input ready);
	modport sink   (input valid, digit_enable, segments, output ready);
endinterface

// ----- rtl/adcbcd_div.sv -----
// Restoring divider: one quotient bit per cycle over DIV_W quotient bits.
// Depends on adcbcd_pkg for widths and the request/response structs.
module adcbcd_div import adcbcd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;

	logic [DVS_W:0] trial;
	logic [DVS_W:0] diff;
	logic           fits;

	// Shift the next dividend bit into the remainder and try the subtraction.
	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ----- rtl/adc_average_to_bcd_7seg_display.sv -----
// Top level of the averaging two-digit seven-segment voltmeter.
// Depends on adcbcd_pkg, the channel interfaces in adcbcd_if and adcbcd_div.
//
// The block takes requests on one channel: a converter sample (cmd 0) or a display
// refresh tick (cmd 1). Samples are summed until samples_per_average of them have
// arrived (a count of 0 acts as 1, counts above MAX_SAMPLES act as MAX_SAMPLES);
// the sum is then divided by that count, saturated to 1023, scaled as
// (avg*45+511)/1023+20 and held for display. The display shows 00 until the
// first average is formed. Each tick yields one result: the seven-segment code
// of one digit of the held value and its digit enable, alternating low digit,
// high digit, starting with the low one. A sample yields no result. A sample
// that completes an average passes in order through the accepting state, the
// count check that also starts the divider, the restoring divider (one quotient
// bit per cycle over 16 bits, then a report of completion), the scaling multiply
// and the divide by 1023, which is a shift-and-add since 1023 is one less than a
// power of two; any other sample returns from the count check to idle. Ready is
// low while a sample is checked or an average is being formed, and also while a
// finished display result is waiting and the output side is not taking it. The
// configuration register sits at byte address 0 of the APB-style port and is
// only to be written while the block is idle.
module adc_average_to_bcd_7seg_display import adcbcd_pkg::*; #(
	parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	adcbcd_in_if.sink          in_ch,
	adcbcd_out_if.source       out_ch
);

	localparam logic [CFG_W-1:0] MAX_CNT = CFG_W'(MAX_SAMPLES);

	// Configuration register and accumulator state.
	logic [CFG_W-1:0]   spa_q;
	logic [SUM_W-1:0]   sum_q;
	logic [CFG_W-1:0]   taken_q;
	logic [SHOWN_W-1:0] shown_q;
	logic               high_q;
	logic [SAMPLE_W-1:0] avg_q;
	logic [DIV_W-1:0]   scaled_q;
	state_t             state_q;
	state_t             state_d;

	// Output register, which parts the request side from the result side.
	logic               out_vld_q;
	logic [DEN_W-1:0]   out_den_q;
	logic [SEG_W-1:0]   out_seg_q;

	logic               cfg_wr;
	logic [CFG_W-1:0]   eff_cnt;
	logic               in_fire;
	logic               tick_fire;
	logic               sample_fire;
	logic               avg_due;
	logic [DIV_W-1:0]   scaled;
	logic [DIV_W-1:0]   recip_sum;
	bcd_t               bcd;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	// A write lands on the access phase; pready is tied high.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_SPA: prdata = {{(32 - CFG_W){1'b0}}, spa_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spa_q <= SPA_RESET;
		end else if (cfg_wr && (paddr[2] == REG_SPA)) begin
			spa_q <= pwdata[CFG_W-1:0];
		end
	end

	// The count actually used: zero acts as one, large values clamp.
	always_comb begin
		if (spa_q == '0) begin
			eff_cnt = CFG_W'(1);
		end else if (spa_q > MAX_CNT) begin
			eff_cnt = MAX_CNT;
		end else begin
			eff_cnt = spa_q;
		end
	end

	assign in_fire     = in_ch.valid && in_ch.ready;
	assign tick_fire   = in_fire && (in_ch.cmd == CMD_TICK);
	assign sample_fire = in_fire && (in_ch.cmd == CMD_SAMPLE);
	assign avg_due     = taken_q >= eff_cnt;

	// The scale step is a small constant multiply plus the rounding offset.
	assign scaled = 16'(DIV_W'(avg_q) * SCALE_MUL) + SCALE_RND;

	// Division by 2**k - 1: adding the value shifted down by k plus one and then
	// shifting by k gives the exact quotient while the quotient stays below 2**k.
	assign recip_sum = scaled_q + (scaled_q >> SCALE_SHIFT) + DIV_W'(1);

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_fire) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = avg_due ? ST_DIV1 : ST_IDLE;
			end
			ST_DIV1: begin
				if (div_rsp.done) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: request readiness and divider starts.
	always_comb begin
		in_ch.ready      = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = DIV_W'(sum_q);
		div_req.divisor  = DVS_W'(eff_cnt);
		unique case (state_q)
			ST_IDLE: begin
				in_ch.ready = !out_vld_q || out_ch.ready;
			end
			ST_CHECK: begin
				div_req.start = avg_due;
			end
			ST_DIV1, ST_SCALE, ST_FINISH: begin
				div_req.start = 1'b0;
			end
			default: in_ch.ready = 1'b0;
		endcase
	end

	adcbcd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q   <= '0;
			taken_q <= '0;
			shown_q <= '0;
			high_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sample_fire) begin
				sum_q   <= sum_q + SUM_W'(in_ch.sample);
				taken_q <= taken_q + 1'b1;
			end
			if (tick_fire) begin
				high_q <= !high_q;
			end
			// The divide by 1023 completes the average: hold it and restart the sum.
			if (state_q == ST_FINISH) begin
				shown_q <= SHOWN_W'(recip_sum[DIV_W-1:SCALE_SHIFT]) + SCALE_OFS;
				sum_q   <= '0;
				taken_q <= '0;
			end
		end
	end

	// The first quotient may exceed ten bits when the count was lowered mid-sum.
	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV1) && div_rsp.done) begin
			if (div_rsp.quotient > DIV_W'(AVG_MAX)) begin
				avg_q <= AVG_MAX;
			end else begin
				avg_q <= div_rsp.quotient[SAMPLE_W-1:0];
			end
		end
		if (state_q == ST_SCALE) begin
			scaled_q <= scaled;
		end
	end

	assign bcd = to_bcd(shown_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (tick_fire) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_fire) begin
			out_den_q <= high_q ? DEN_HIGH : DEN_LOW;
			out_seg_q <= seg_code(high_q ? bcd.tens : bcd.units);
		end
	end

	assign out_ch.valid        = out_vld_q;
	assign out_ch.digit_enable = out_den_q;
	assign out_ch.segments     = out_seg_q;

	// The held value is either the reset value or inside the scaled range.
	a_shown_range: assert property (@(posedge clk) disable iff (!arst_n)
		shown_q == '0 || (shown_q >= SCALE_OFS && shown_q <= 7'd65))
		else $error("held display value out of range");

	// The divider only reports completion while the sequencer waits for it.
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV1))
		else $error("divider finished outside the divide state");

	// The sample count never runs past the largest average length.
	a_taken_bound: assert property (@(posedge clk) disable iff (!arst_n)
		taken_q <= MAX_CNT)
		else $error("sample count exceeded the maximum");

	// A tick while a result waits must not be taken unless that result leaves.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_ch.ready) |-> !tick_fire)
		else $error("pending display result would be overwritten");

endmodule
